### hw/rtl/pdr_pkg.sv
// Package for the PI distance regulator.
// Holds field widths, register indexes, reset values and sequencer codes.
// No dependencies.
`default_nettype none
package pdr_pkg;

  localparam int unsigned CfgW   = 16;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned ErrW   = 17;
  localparam int unsigned IntW   = 32;
  localparam int unsigned UpW    = 33;
  localparam int unsigned ProdW  = 49;
  localparam int unsigned SumW   = 25;
  localparam int unsigned CmdW   = 17;
  localparam int unsigned SpdW   = 16;

  typedef logic [2:0] reg_idx_t;
  typedef logic [2:0] seq_state_t;

  localparam reg_idx_t REG_TARGET = 3'd0;
  localparam reg_idx_t REG_KP     = 3'd1;
  localparam reg_idx_t REG_KI     = 3'd2;
  localparam reg_idx_t REG_MAX    = 3'd3;
  localparam reg_idx_t REG_STEPS  = 3'd4;

  localparam logic [CfgW-1:0] RST_TARGET = 16'd2560;
  localparam logic [CfgW-1:0] RST_KP     = 16'd1280;
  localparam logic [CfgW-1:0] RST_KI     = 16'd51;
  localparam logic [CfgW-1:0] RST_MAX    = 16'd2560;
  localparam logic [CfgW-1:0] RST_STEPS  = 16'd19692;

  localparam seq_state_t S_IDLE  = 3'd0;
  localparam seq_state_t S_PROP  = 3'd1;
  localparam seq_state_t S_INTG  = 3'd2;
  localparam seq_state_t S_CLAMP = 3'd3;
  localparam seq_state_t S_SPEED = 3'd4;
  localparam seq_state_t S_DONE  = 3'd5;

endpackage
`default_nettype wire

### hw/rtl/pi_distance_regulator.sv
// PI distance regulator: error, saturating integral, clamped PI sum, speed scaling.
// Steps PROP, INTG, CLAMP, SPEED, DONE follow an accept; no new request until IDLE.
// One shared 17x33 multiplier is used for the P, I and speed products in turn.
// Ready only while the sequencer idles; a waiting result stalls the last step.
// rst_n synchronous: integral cleared, registers to their reset values.
// Depends on pdr_pkg.
`default_nettype none
module pi_distance_regulator (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [15:0]                  in_distance,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [15:0]           out_motor_speed,
  output logic signed [16:0]           out_command,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [pdr_pkg::AddrW-1:0]    paddr,
  input  wire  [pdr_pkg::DataW-1:0]    pwdata,
  output logic [pdr_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  logic [pdr_pkg::CfgW-1:0] target_r, kp_r, ki_r, max_r, steps_r;
  pdr_pkg::reg_idx_t        widx;

  pdr_pkg::seq_state_t      state_r, state_nxt;
  logic signed [pdr_pkg::ErrW-1:0]  err_r;
  logic signed [pdr_pkg::IntW-1:0]  integral_r;
  logic signed [pdr_pkg::UpW-1:0]   up_r;
  logic signed [pdr_pkg::ProdW-1:0] prod_r;
  logic signed [pdr_pkg::SumW-1:0]  sum_r;
  logic                             out_valid_r;
  logic signed [pdr_pkg::SpdW-1:0]  spd_r;
  logic signed [pdr_pkg::CmdW-1:0]  cmd_r;

  logic signed [pdr_pkg::ErrW-1:0]  err_nxt;
  logic signed [pdr_pkg::IntW:0]    int_sum;
  logic signed [pdr_pkg::IntW-1:0]  integral_nxt;
  logic signed [16:0]               mul_a;
  logic signed [pdr_pkg::UpW-1:0]   mul_b;
  logic signed [49:0]               mul_p;
  logic signed [pdr_pkg::ProdW-1:0] total, lim, neg_lim;
  logic signed [pdr_pkg::SumW-1:0]  sum_nxt;
  logic signed [pdr_pkg::SumW:0]    cmd_adj;
  logic signed [pdr_pkg::ProdW-1:0] spd_adj;
  logic signed [pdr_pkg::SumW-1:0]  spd_q;
  logic signed [pdr_pkg::SpdW-1:0]  spd_nxt;
  logic                             accept, finish;

  // configuration port
  assign pready = 1'b1;
  assign widx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= pdr_pkg::RST_TARGET;
      kp_r     <= pdr_pkg::RST_KP;
      ki_r     <= pdr_pkg::RST_KI;
      max_r    <= pdr_pkg::RST_MAX;
      steps_r  <= pdr_pkg::RST_STEPS;
    end else if (psel && penable && pwrite) begin
      case (widx)
        pdr_pkg::REG_TARGET: target_r <= pwdata[15:0];
        pdr_pkg::REG_KP:     kp_r     <= pwdata[15:0];
        pdr_pkg::REG_KI:     ki_r     <= pwdata[15:0];
        pdr_pkg::REG_MAX:    max_r    <= pwdata[15:0];
        pdr_pkg::REG_STEPS:  steps_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      pdr_pkg::REG_TARGET: prdata = {16'd0, target_r};
      pdr_pkg::REG_KP:     prdata = {16'd0, kp_r};
      pdr_pkg::REG_KI:     prdata = {16'd0, ki_r};
      pdr_pkg::REG_MAX:    prdata = {16'd0, max_r};
      pdr_pkg::REG_STEPS:  prdata = {16'd0, steps_r};
      default:             prdata = '0;
    endcase
  end

  // handshake
  assign in_ready  = (state_r == pdr_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign finish    = (state_r == pdr_pkg::S_DONE) && (!out_valid_r || out_ready);

  // error and saturating integral
  assign err_nxt = $signed({1'b0, in_distance}) - $signed({1'b0, target_r});
  assign int_sum = {integral_r[pdr_pkg::IntW-1], integral_r}
                 + {{(pdr_pkg::IntW+1-pdr_pkg::ErrW){err_nxt[pdr_pkg::ErrW-1]}}, err_nxt};

  always_comb begin
    if (int_sum[pdr_pkg::IntW] != int_sum[pdr_pkg::IntW-1]) begin
      integral_nxt = int_sum[pdr_pkg::IntW] ? {1'b1, {(pdr_pkg::IntW-1){1'b0}}}
                                            : {1'b0, {(pdr_pkg::IntW-1){1'b1}}};
    end else begin
      integral_nxt = int_sum[pdr_pkg::IntW-1:0];
    end
  end

  // shared multiplier
  always_comb begin
    case (state_r)
      pdr_pkg::S_PROP: begin
        mul_a = $signed({1'b0, kp_r});
        mul_b = {{(pdr_pkg::UpW-pdr_pkg::ErrW){err_r[pdr_pkg::ErrW-1]}}, err_r};
      end
      pdr_pkg::S_INTG: begin
        mul_a = $signed({1'b0, ki_r});
        mul_b = {integral_r[pdr_pkg::IntW-1], integral_r};
      end
      pdr_pkg::S_SPEED: begin
        mul_a = $signed({1'b0, steps_r});
        mul_b = {{(pdr_pkg::UpW-pdr_pkg::SumW){sum_r[pdr_pkg::SumW-1]}}, sum_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // clamp of the PI sum
  assign total   = {{(pdr_pkg::ProdW-pdr_pkg::UpW){up_r[pdr_pkg::UpW-1]}}, up_r} + prod_r;
  assign lim     = $signed({25'd0, max_r, 8'd0});
  assign neg_lim = -lim;

  always_comb begin
    if (total > lim) begin
      sum_nxt = lim[pdr_pkg::SumW-1:0];
    end else if (total < neg_lim) begin
      sum_nxt = neg_lim[pdr_pkg::SumW-1:0];
    end else begin
      sum_nxt = total[pdr_pkg::SumW-1:0];
    end
  end

  // truncate toward zero, saturate speed
  assign cmd_adj = {sum_r[pdr_pkg::SumW-1], sum_r}
                 + (sum_r[pdr_pkg::SumW-1] ? 26'sd255 : 26'sd0);
  assign spd_adj = prod_r + (prod_r[pdr_pkg::ProdW-1] ? 49'sd16777215 : 49'sd0);
  assign spd_q   = spd_adj[48:24];

  always_comb begin
    if (spd_q > 25'sd32767) begin
      spd_nxt = 16'sh7fff;
    end else if (spd_q < -25'sd32768) begin
      spd_nxt = 16'sh8000;
    end else begin
      spd_nxt = spd_q[15:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pdr_pkg::S_IDLE:  if (accept) state_nxt = pdr_pkg::S_PROP;
      pdr_pkg::S_PROP:  state_nxt = pdr_pkg::S_INTG;
      pdr_pkg::S_INTG:  state_nxt = pdr_pkg::S_CLAMP;
      pdr_pkg::S_CLAMP: state_nxt = pdr_pkg::S_SPEED;
      pdr_pkg::S_SPEED: state_nxt = pdr_pkg::S_DONE;
      pdr_pkg::S_DONE:  if (finish) state_nxt = pdr_pkg::S_IDLE;
      default:          state_nxt = pdr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pdr_pkg::S_IDLE;
      integral_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        integral_r <= integral_nxt;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err_r <= err_nxt;
    end
    case (state_r)
      pdr_pkg::S_PROP:  prod_r <= mul_p[pdr_pkg::ProdW-1:0];
      pdr_pkg::S_INTG: begin
        up_r   <= prod_r[pdr_pkg::UpW-1:0];
        prod_r <= mul_p[pdr_pkg::ProdW-1:0];
      end
      pdr_pkg::S_CLAMP: sum_r  <= sum_nxt;
      pdr_pkg::S_SPEED: prod_r <= mul_p[pdr_pkg::ProdW-1:0];
      default: ;
    endcase
    if (finish) begin
      spd_r <= spd_nxt;
      cmd_r <= cmd_adj[24:8];
    end
  end

  assign out_motor_speed = spd_r;
  assign out_command     = cmd_r;

endmodule
`default_nettype wire
